// File: design/lcss_pkg.sv
// Shared constants, command codes and segment encoding for the event counter display.
package lcss_pkg;

    localparam int CMD_W      = 4;
    localparam int SWITCH_W   = 10;
    localparam int COUNT_W    = 32;
    localparam int VALUE_W    = 20;
    localparam int DIGITS     = 6;
    localparam int CODE_W     = 8;
    localparam int CODES_W    = DIGITS * CODE_W;
    localparam int MUL_W      = 20;

    localparam logic [CMD_W-1:0]   CMD_LOAD    = 4'd1;
    localparam logic [CMD_W-1:0]   CMD_INC     = 4'd2;
    localparam logic [COUNT_W-1:0] DISPLAY_MAX = 32'd999999;

    // reciprocal constants, exact for every value up to 999999
    localparam int               DIV10_SHIFT   = 23;
    localparam int               DIV100_SHIFT  = 26;
    localparam int               DIV1K_SHIFT   = 29;
    localparam int               DIV10K_SHIFT  = 32;
    localparam int               DIV100K_SHIFT = 36;
    localparam logic [MUL_W-1:0] DIV10_MUL     = 20'd838861; // ceil(2^23 / 10)
    localparam logic [MUL_W-1:0] DIV100_MUL    = 20'd671089; // ceil(2^26 / 100)
    localparam logic [MUL_W-1:0] DIV1K_MUL     = 20'd536871; // ceil(2^29 / 1000)
    localparam logic [MUL_W-1:0] DIV10K_MUL    = 20'd429497; // ceil(2^32 / 10000)
    localparam logic [MUL_W-1:0] DIV100K_MUL   = 20'd687195; // ceil(2^36 / 100000)

    function automatic logic [CODE_W-1:0] seg_code(input logic [3:0] digit);
        logic [CODE_W-1:0] code;
        unique case (digit)
            4'd0:    code = 8'h3F;
            4'd1:    code = 8'h06;
            4'd2:    code = 8'h5B;
            4'd3:    code = 8'h4F;
            4'd4:    code = 8'h66;
            4'd5:    code = 8'h6D;
            4'd6:    code = 8'h7D;
            4'd7:    code = 8'h07;
            4'd8:    code = 8'h7F;
            4'd9:    code = 8'h6F;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

// File: design/lcss_digit_stage.sv
// Registered conversion of the displayed value into six segment codes in one pass.
module lcss_digit_stage (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [lcss_pkg::VALUE_W-1:0]  in_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lcss_pkg::CODES_W-1:0]  out_codes
);

    localparam int PROD_W = lcss_pkg::VALUE_W + lcss_pkg::MUL_W;

    logic                          valid_reg;
    logic [lcss_pkg::CODES_W-1:0]  codes_reg;
    logic [lcss_pkg::CODES_W-1:0]  codes_next;
    logic [PROD_W-1:0]             prod     [1:lcss_pkg::DIGITS-1];
    logic [3:0]                    quot_low [0:lcss_pkg::DIGITS-1];
    logic [3:0]                    digit    [0:lcss_pkg::DIGITS-1];

    // value / 10^k for every k in parallel; only the low nibble of each quotient matters
    always_comb begin
        prod[1] = PROD_W'(in_value) * PROD_W'(lcss_pkg::DIV10_MUL);
        prod[2] = PROD_W'(in_value) * PROD_W'(lcss_pkg::DIV100_MUL);
        prod[3] = PROD_W'(in_value) * PROD_W'(lcss_pkg::DIV1K_MUL);
        prod[4] = PROD_W'(in_value) * PROD_W'(lcss_pkg::DIV10K_MUL);
        prod[5] = PROD_W'(in_value) * PROD_W'(lcss_pkg::DIV100K_MUL);
        quot_low[0] = in_value[3:0];
        quot_low[1] = prod[1][lcss_pkg::DIV10_SHIFT +: 4];
        quot_low[2] = prod[2][lcss_pkg::DIV100_SHIFT +: 4];
        quot_low[3] = prod[3][lcss_pkg::DIV1K_SHIFT +: 4];
        quot_low[4] = prod[4][lcss_pkg::DIV10K_SHIFT +: 4];
        quot_low[5] = prod[5][lcss_pkg::DIV100K_SHIFT +: 4];
        // digit k = q_k - 10 * q_(k+1), taken mod 16
        for (int k = 0; k < lcss_pkg::DIGITS - 1; k++) begin
            digit[k] = quot_low[k] - {quot_low[k+1][0], 3'b000}
                     - {quot_low[k+1][2:0], 1'b0};
        end
        digit[lcss_pkg::DIGITS-1] = quot_low[lcss_pkg::DIGITS-1];
        for (int k = 0; k < lcss_pkg::DIGITS; k++) begin
            codes_next[k*lcss_pkg::CODE_W +: lcss_pkg::CODE_W] = lcss_pkg::seg_code(digit[k]);
        end
    end

    assign in_ready = ~valid_reg | out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            codes_reg <= codes_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_codes = codes_reg;

endmodule

// File: design/loadable_counter_seven_segment_core.sv
// Top level: loadable 32-bit event counter with a six-digit seven-segment readout.
//
//  channel | dir | tdata fields (low bit up)                     | beat
//  s_      | in  | command[3:0], switch_value[13:4], zero pad     | one button event
//  m_      | out | display_low[31:0], display_high[47:32]        | one display update
//
//  One beat in and one beat out per cycle, sustained while m_tready is high.
//  The path runs through the counter/saturate register, then the segment register,
//  fed by six digit extractions built on five parallel reciprocal multiplies.
//  Reset clears the counter and both valid flags.
//  Each register takes a new beat whenever it is empty or its successor moves,
//  so bubbles collapse while m_tready is low.
module loadable_counter_seven_segment_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // command[3:0], switch_value[13:4], pad[15:14]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // display_low[31:0], display_high[47:32]
);

    logic [lcss_pkg::CMD_W-1:0]    command;
    logic [lcss_pkg::SWITCH_W-1:0] switch_value;
    logic [lcss_pkg::COUNT_W-1:0]  count_reg;
    logic [lcss_pkg::COUNT_W-1:0]  count_next;
    logic [lcss_pkg::VALUE_W-1:0]  shown_reg;
    logic [lcss_pkg::VALUE_W-1:0]  shown_next;
    logic                          shown_valid_reg;
    logic                          s_accept;
    logic                          conv_ready;

    assign command      = s_tdata[3:0];
    assign switch_value = s_tdata[13:4];
    assign s_tready     = ~shown_valid_reg | conv_ready;
    assign s_accept     = s_tvalid & s_tready;

    always_comb begin
        priority if (command == lcss_pkg::CMD_LOAD) begin
            count_next = lcss_pkg::COUNT_W'(switch_value);
        end else if (command == lcss_pkg::CMD_INC) begin
            count_next = count_reg + lcss_pkg::COUNT_W'(1);
        end else begin
            count_next = count_reg;
        end
        shown_next = (count_next > lcss_pkg::DISPLAY_MAX)
                   ? lcss_pkg::DISPLAY_MAX[lcss_pkg::VALUE_W-1:0]
                   : count_next[lcss_pkg::VALUE_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg       <= '0;
            shown_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                count_reg <= count_next;
            end
            if (s_tready) begin
                shown_valid_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            shown_reg <= shown_next;
        end
    end

    lcss_digit_stage u_digits (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (shown_valid_reg),
        .in_ready  (conv_ready),
        .in_value  (shown_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_codes (m_tdata)
    );

endmodule

// File: tb/loadable_counter_seven_segment_core_test.sv
// Self-checking stream testbench for the loadable counter with seven-segment readout.
module loadable_counter_seven_segment_core_test;

    localparam int PIPE_LATENCY = 2;
    localparam int INC_RUN      = 40;
    localparam int PHASE_EVENTS = 425;
    localparam int MAX_PRINTS   = 40;

    localparam logic [lcss_pkg::CMD_W-1:0] CMD_NONE  = 4'd0;
    localparam logic [lcss_pkg::CMD_W-1:0] CMD_BOTH  = 4'd3;
    localparam logic [lcss_pkg::CMD_W-1:0] CMD_EDGE2 = 4'd4;
    localparam logic [lcss_pkg::CMD_W-1:0] CMD_EDGE3 = 4'd8;
    localparam logic [lcss_pkg::CMD_W-1:0] CMD_ALL   = 4'd15;

    localparam logic [7:0] SEGMENTS [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    typedef struct packed {
        logic [15:0] high;
        logic [31:0] low;
    } display_t;

    typedef struct packed {
        logic [lcss_pkg::CMD_W-1:0]    cmd;
        logic [lcss_pkg::SWITCH_W-1:0] sw;
        logic                          typed;
        display_t                      disp;
    } event_row_t;

    localparam int N_ROWS = 16;
    localparam event_row_t DIRECTED_ROWS [N_ROWS] = '{
        '{CMD_NONE,  10'h000, 1'b1, '{16'h3F3F, 32'h3F3F3F3F}},
        '{lcss_pkg::CMD_LOAD, 10'h3FF, 1'b1, '{16'h3F3F, 32'h063F5B4F}},
        '{lcss_pkg::CMD_INC,  10'h000, 1'b1, '{16'h3F3F, 32'h063F5B66}},
        '{CMD_BOTH,  10'h155, 1'b1, '{16'h3F3F, 32'h063F5B66}},
        '{CMD_ALL,   10'h3FF, 1'b1, '{16'h3F3F, 32'h063F5B66}},
        '{lcss_pkg::CMD_LOAD, 10'h000, 1'b1, '{16'h3F3F, 32'h3F3F3F3F}},
        '{lcss_pkg::CMD_INC,  10'h3FF, 1'b1, '{16'h3F3F, 32'h3F3F3F06}},
        '{CMD_EDGE2, 10'h2AA, 1'b0, '{16'h0000, 32'h00000000}},
        '{CMD_EDGE3, 10'h155, 1'b0, '{16'h0000, 32'h00000000}},
        '{lcss_pkg::CMD_LOAD, 10'h155, 1'b0, '{16'h0000, 32'h00000000}},
        '{lcss_pkg::CMD_LOAD, 10'h2AA, 1'b0, '{16'h0000, 32'h00000000}},
        '{lcss_pkg::CMD_LOAD, 10'd999, 1'b1, '{16'h3F3F, 32'h3F6F6F6F}},
        '{lcss_pkg::CMD_INC,  10'h000, 1'b1, '{16'h3F3F, 32'h063F3F3F}},
        '{lcss_pkg::CMD_INC,  10'h3FF, 1'b0, '{16'h0000, 32'h00000000}},
        '{lcss_pkg::CMD_LOAD, 10'd456, 1'b0, '{16'h0000, 32'h00000000}},
        '{CMD_BOTH,  10'd789, 1'b0, '{16'h0000, 32'h00000000}}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // command[3:0], switch_value[13:4], pad[15:14]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // display_low[31:0], display_high[47:32]

    logic [lcss_pkg::COUNT_W-1:0] event_total = '0;
    display_t           pending_displays [$];
    display_t           wanted;
    int unsigned        send_idle_pct = 0;
    int unsigned        stall_pct     = 0;
    int unsigned        mismatches    = 0;
    int unsigned        events_sent   = 0;
    int unsigned        displays_seen = 0;

    loadable_counter_seven_segment_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    function automatic display_t segments_for(input logic [lcss_pkg::COUNT_W-1:0] total);
        logic [lcss_pkg::COUNT_W-1:0] shown;
        logic [47:0]        codes;
        int unsigned        div;
        shown = (total > lcss_pkg::DISPLAY_MAX) ? lcss_pkg::DISPLAY_MAX : total;
        codes = '0;
        div   = 1;
        for (int d = 0; d < lcss_pkg::DIGITS; d++) begin
            codes[d*8 +: 8] = SEGMENTS[(shown / div) % 10];
            div = div * 10;
        end
        return display_t'(codes);
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatches < MAX_PRINTS)
            $display("mismatch @%0t: %s got %h want %h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic send_event(input logic [lcss_pkg::CMD_W-1:0] cmd,
                              input logic [lcss_pkg::SWITCH_W-1:0] sw,
                              input logic typed, input display_t typed_disp);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, sw, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (cmd == lcss_pkg::CMD_LOAD)
            event_total = {{(lcss_pkg::COUNT_W-lcss_pkg::SWITCH_W){1'b0}}, sw};
        else if (cmd == lcss_pkg::CMD_INC)
            event_total = event_total + 1'b1;
        pending_displays.push_back(typed ? typed_disp : segments_for(event_total));
        events_sent++;
    endtask

    task automatic drain_displays();
        s_tvalid <= 1'b0;
        while (pending_displays.size() != 0) @(posedge aclk);
    endtask

    // display checker and receiver back-pressure
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            displays_seen++;
            if (pending_displays.size() == 0) begin
                flag_mismatch("unexpected display beat", m_tdata[31:0], 32'h0);
            end else begin
                wanted = pending_displays.pop_front();
                if (m_tdata[31:0] !== wanted.low)
                    flag_mismatch("display_low", m_tdata[31:0], wanted.low);
                if (m_tdata[47:32] !== wanted.high)
                    flag_mismatch("display_high", {16'h0, m_tdata[47:32]}, {16'h0, wanted.high});
            end
        end
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin
        #80_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        logic [lcss_pkg::CMD_W-1:0] cmd;
        int unsigned      pick;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < N_ROWS; r++)
            send_event(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].sw,
                       DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].disp);

        // count up from the largest load at full rate
        send_event(lcss_pkg::CMD_LOAD, 10'h3FF, 1'b1, '{16'h3F3F, 32'h063F5B4F});
        for (int i = 0; i < INC_RUN; i++)
            send_event(lcss_pkg::CMD_INC, lcss_pkg::SWITCH_W'($urandom), 1'b0, '0);
        send_event(CMD_NONE, 10'h000, 1'b1, '{16'h3F3F, 32'h063F7D4F});
        send_event(lcss_pkg::CMD_LOAD, 10'h000, 1'b1, '{16'h3F3F, 32'h3F3F3F3F});
        drain_displays();

        for (int phase = 0; phase < 4; phase++) begin
            unique case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 64; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 64; end
                default: begin send_idle_pct = 13; stall_pct = 13; end
            endcase
            for (int i = 0; i < PHASE_EVENTS; i++) begin
                pick = $urandom_range(99);
                if (pick < 40)
                    cmd = lcss_pkg::CMD_INC;
                else if (pick < 70)
                    cmd = lcss_pkg::CMD_LOAD;
                else
                    cmd = lcss_pkg::CMD_W'($urandom);
                send_event(cmd, lcss_pkg::SWITCH_W'($urandom), 1'b0, '0);
            end
            drain_displays();
        end

        repeat (PIPE_LATENCY * 4) @(posedge aclk);
        if (pending_displays.size() != 0)
            flag_mismatch("displays never delivered", pending_displays.size(), 32'h0);

        $display("covered %0d button events, incl. an increment run, over four idle mixes",
                 events_sent);
        $display("%0d display beats checked, %0d mismatches", displays_seen, mismatches);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
design/lcss_pkg.sv
design/lcss_digit_stage.sv
design/loadable_counter_seven_segment_core.sv
tb/loadable_counter_seven_segment_core_test.sv
